// ===== rtl/ray_sphere_intersect_defines.svh =====
// ---------------------------------------------------------------------------
// ray_sphere_intersect assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RSI_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ray_sphere_intersect check failed");

// next-cycle implication
`define RSI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ray_sphere_intersect check failed");

`else

`define RSI_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define RSI_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/rsi_pkg.sv =====
// ---------------------------------------------------------------------------
// rsi_pkg
// shared widths, hit codes and the coefficient bundle of the intersect pipe
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

   localparam int FRACTION_BITS = 16;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int A_W     = 64;
   localparam int H_W     = 66;
   localparam int C_W     = 68;
   localparam int Q_W     = 132;
   localparam int ROOT_W  = Q_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int DIST_W  = 68;
   localparam int MAG_W   = DIST_W + FRACTION_BITS;
   localparam int OUT_W   = 32;
   localparam int MHI_W   = MAG_W - OUT_W;

   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_ONE  = 2'd1;
   localparam logic [1:0] HIT_TWO  = 2'd2;

   typedef struct packed {
      logic           miss;
      logic           q_zero;
      logic [A_W-1:0] a;
      logic [H_W-1:0] h;
   } coef_type;

endpackage

`default_nettype wire

// ===== rtl/rsi_coef.sv =====
// ---------------------------------------------------------------------------
// rsi_coef
// seven stage front end: a, half b, c and the quarter discriminant q
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_coef
   import rsi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [2:0][COORD_W-1:0] in_origin,
   input  logic [2:0][COORD_W-1:0] in_direction,
   input  logic [2:0][COORD_W-1:0] in_centre,
   output logic                    out_valid,
   output coef_type                out_coef,
   output logic [Q_W-1:0]          out_q
);

   localparam int H_SPLIT = 33;
   localparam int A_SPLIT = 32;
   localparam int C_SPLIT = 34;
   localparam int HH_W    = H_W - H_SPLIT;
   localparam int HL_W    = H_SPLIT + 1;
   localparam int AL_W    = A_SPLIT + 1;
   localparam int AH_W    = A_W - A_SPLIT + 1;
   localparam int CL_W    = C_SPLIT + 1;
   localparam int CH_W    = C_W - C_SPLIT;
   localparam int PHH_W   = 2 * HH_W;
   localparam int PHM_W   = HH_W + HL_W;
   localparam int PLL_W   = 2 * HL_W;
   localparam int PACLL_W = AL_W + CL_W;
   localparam int PACLH_W = AL_W + CH_W;
   localparam int PACHL_W = AH_W + CL_W;
   localparam int PACHH_W = AH_W + CH_W;
   localparam logic signed [C_W-1:0] C_ONE = C_W'(1) << (2 * FRACTION_BITS);

   logic st1_valid_ff, st2_valid_ff, st3_valid_ff, st4_valid_ff;
   logic st5_valid_ff, st6_valid_ff, st7_valid_ff;

   // stage 1: origin relative to centre
   logic signed [COORD_W-1:0] dir_st1_in [3];
   logic signed [COORD_W-1:0] dir_st1_ff [3];
   logic signed [DIFF_W-1:0]  rel_st1_in [3];
   logic signed [DIFF_W-1:0]  rel_st1_ff [3];

   // stage 2: per axis products
   logic signed [A_W-1:0]   dd_st2_in [3];
   logic signed [A_W-1:0]   dd_st2_ff [3];
   logic signed [A_W:0]     dr_st2_in [3];
   logic signed [A_W:0]     dr_st2_ff [3];
   logic signed [A_W+1:0]   rr_st2_in [3];
   logic signed [A_W+1:0]   rr_st2_ff [3];

   // stage 3: dot products
   logic [A_W-1:0]        a_st3_in, a_st3_ff;
   logic signed [H_W-1:0] h_st3_in, h_st3_ff;
   logic signed [C_W-1:0] c_st3_in, c_st3_ff;

   // stage 4: partial products of h*h and a*c
   logic signed [HH_W-1:0]    hh;
   logic signed [HL_W-1:0]    hl;
   logic signed [AL_W-1:0]    al;
   logic signed [AH_W-1:0]    ah;
   logic signed [CL_W-1:0]    cl;
   logic signed [CH_W-1:0]    ch;
   logic signed [PHH_W-1:0]   p_hh_in, p_hh_ff;
   logic signed [PHM_W-1:0]   p_hm_in, p_hm_ff;
   logic signed [PLL_W-1:0]   p_ll_in, p_ll_ff;
   logic signed [PACLL_W-1:0] p_acll_in, p_acll_ff;
   logic signed [PACLH_W-1:0] p_aclh_in, p_aclh_ff;
   logic signed [PACHL_W-1:0] p_achl_in, p_achl_ff;
   logic signed [PACHH_W-1:0] p_achh_in, p_achh_ff;
   coef_type                  coef_st4_in, coef_st4_ff;

   // stage 5 and 6: recombine, subtract
   logic signed [Q_W-1:0] h2_st5_in, h2_st5_ff;
   logic signed [Q_W-1:0] ac_st5_in, ac_st5_ff;
   coef_type              coef_st5_ff;
   logic signed [Q_W-1:0] q_st6_in, q_st6_ff;
   coef_type              coef_st6_ff;

   // stage 7: flags
   coef_type              coef_st7_in, coef_st7_ff;
   logic [Q_W-1:0]        q_st7_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_st1_in[i] = $signed(in_direction[i]);
         rel_st1_in[i] = DIFF_W'($signed(in_origin[i])) - DIFF_W'($signed(in_centre[i]));
         dd_st2_in[i]  = A_W'(dir_st1_ff[i]) * A_W'(dir_st1_ff[i]);
         dr_st2_in[i]  = (A_W + 1)'(dir_st1_ff[i]) * (A_W + 1)'(rel_st1_ff[i]);
         rr_st2_in[i]  = (A_W + 2)'(rel_st1_ff[i]) * (A_W + 2)'(rel_st1_ff[i]);
      end
   end

   always_comb begin
      a_st3_in = A_W'(dd_st2_ff[0]) + A_W'(dd_st2_ff[1]) + A_W'(dd_st2_ff[2]);
      h_st3_in = H_W'(dr_st2_ff[0]) + H_W'(dr_st2_ff[1]) + H_W'(dr_st2_ff[2]);
      c_st3_in = C_W'(rr_st2_ff[0]) + C_W'(rr_st2_ff[1]) + C_W'(rr_st2_ff[2]) - C_ONE;
   end

   always_comb begin
      hh = $signed(h_st3_ff[H_W-1:H_SPLIT]);
      hl = $signed({1'b0, h_st3_ff[H_SPLIT-1:0]});
      al = $signed({1'b0, a_st3_ff[A_SPLIT-1:0]});
      ah = $signed({1'b0, a_st3_ff[A_W-1:A_SPLIT]});
      cl = $signed({1'b0, c_st3_ff[C_SPLIT-1:0]});
      ch = $signed(c_st3_ff[C_W-1:C_SPLIT]);
      p_hh_in   = PHH_W'(hh) * PHH_W'(hh);
      p_hm_in   = PHM_W'(hh) * PHM_W'(hl);
      p_ll_in   = PLL_W'(hl) * PLL_W'(hl);
      p_acll_in = PACLL_W'(al) * PACLL_W'(cl);
      p_aclh_in = PACLH_W'(al) * PACLH_W'(ch);
      p_achl_in = PACHL_W'(ah) * PACHL_W'(cl);
      p_achh_in = PACHH_W'(ah) * PACHH_W'(ch);
      coef_st4_in.miss   = (a_st3_ff == '0);
      coef_st4_in.q_zero = 1'b0;
      coef_st4_in.a      = a_st3_ff;
      coef_st4_in.h      = h_st3_ff;
   end

   always_comb begin
      h2_st5_in = (Q_W'(p_hh_ff) <<< (2 * H_SPLIT))
                + (Q_W'(p_hm_ff) <<< (H_SPLIT + 1))
                + Q_W'(p_ll_ff);
      ac_st5_in = (Q_W'(p_achh_ff) <<< (A_SPLIT + C_SPLIT))
                + (Q_W'(p_achl_ff) <<< A_SPLIT)
                + (Q_W'(p_aclh_ff) <<< C_SPLIT)
                + Q_W'(p_acll_ff);
      q_st6_in  = h2_st5_ff - ac_st5_ff;
      coef_st7_in        = coef_st6_ff;
      coef_st7_in.miss   = coef_st6_ff.miss | q_st6_ff[Q_W-1];
      coef_st7_in.q_zero = (q_st6_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
         st6_valid_ff <= 1'b0;
         st7_valid_ff <= 1'b0;
      end else if (en) begin
         st1_valid_ff <= in_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
         st5_valid_ff <= st4_valid_ff;
         st6_valid_ff <= st5_valid_ff;
         st7_valid_ff <= st6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_st1_ff  <= dir_st1_in;
         rel_st1_ff  <= rel_st1_in;
         dd_st2_ff   <= dd_st2_in;
         dr_st2_ff   <= dr_st2_in;
         rr_st2_ff   <= rr_st2_in;
         a_st3_ff    <= a_st3_in;
         h_st3_ff    <= h_st3_in;
         c_st3_ff    <= c_st3_in;
         p_hh_ff     <= p_hh_in;
         p_hm_ff     <= p_hm_in;
         p_ll_ff     <= p_ll_in;
         p_acll_ff   <= p_acll_in;
         p_aclh_ff   <= p_aclh_in;
         p_achl_ff   <= p_achl_in;
         p_achh_ff   <= p_achh_in;
         coef_st4_ff <= coef_st4_in;
         h2_st5_ff   <= h2_st5_in;
         ac_st5_ff   <= ac_st5_in;
         coef_st5_ff <= coef_st4_ff;
         q_st6_ff    <= q_st6_in;
         coef_st6_ff <= coef_st5_ff;
         q_st7_ff    <= q_st6_ff;
         coef_st7_ff <= coef_st7_in;
      end
   end

   assign out_valid = st7_valid_ff;
   assign out_coef  = coef_st7_ff;
   assign out_q     = q_st7_ff;

endmodule

`default_nettype wire

// ===== rtl/rsi_isqrt.sv =====
// ---------------------------------------------------------------------------
// rsi_isqrt
// pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_isqrt
   import rsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  coef_type          in_coef,
   input  logic [Q_W-1:0]    in_q,
   output logic              out_valid,
   output coef_type          out_coef,
   output logic [ROOT_W-1:0] out_root
);

   logic              valid_ff [ROOT_W];
   coef_type          coef_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [Q_W-1:0]    qrest_ff [ROOT_W];

   logic              valid_stg [ROOT_W+1];
   coef_type          coef_stg  [ROOT_W+1];
   logic [REM_W-1:0]  rem_stg   [ROOT_W+1];
   logic [ROOT_W-1:0] root_stg  [ROOT_W+1];
   logic [Q_W-1:0]    qrest_stg [ROOT_W+1];

   assign valid_stg[0] = in_valid;
   assign coef_stg[0]  = in_coef;
   assign rem_stg[0]   = '0;
   assign root_stg[0]  = '0;
   assign qrest_stg[0] = in_q;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      // two bits of q come down, try root*4+1
      always_comb begin
         cur     = {rem_stg[k], qrest_stg[k][Q_W-1 -: 2]};
         trial   = (REM_W + 2)'({root_stg[k], 2'b01});
         take    = (cur >= trial);
         rem_in  = take ? REM_W'(cur - trial) : REM_W'(cur);
         root_in = {root_stg[k][ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_stg[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            coef_ff[k]  <= coef_stg[k];
            rem_ff[k]   <= rem_in;
            root_ff[k]  <= root_in;
            qrest_ff[k] <= qrest_stg[k] << 2;
         end
      end

      assign valid_stg[k+1] = valid_ff[k];
      assign coef_stg[k+1]  = coef_ff[k];
      assign rem_stg[k+1]   = rem_ff[k];
      assign root_stg[k+1]  = root_ff[k];
      assign qrest_stg[k+1] = qrest_ff[k];
   end

   assign out_valid = valid_stg[ROOT_W];
   assign out_coef  = coef_stg[ROOT_W];
   assign out_root  = root_stg[ROOT_W];

endmodule

`default_nettype wire

// ===== rtl/rsi_divide.sv =====
// ---------------------------------------------------------------------------
// rsi_divide
// near and far numerators, two-lane restoring divider, floor and saturation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_divide
   import rsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  coef_type          in_coef,
   input  logic [ROOT_W-1:0] in_root,
   output logic              out_valid,
   output logic [1:0]        out_hit_count,
   output logic [OUT_W-1:0]  out_near,
   output logic [OUT_W-1:0]  out_far
);

   localparam int DIV_STAGES = OUT_W;
   localparam logic [OUT_W-1:0] DIST_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic [OUT_W-1:0] DIST_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [A_W-1:0]   rem;
      logic [OUT_W-1:0] quo;
      logic [OUT_W-1:0] mlo;
   } lane_type;

   // stage 1: -h -/+ s
   logic signed [DIST_W-1:0] h_ext, s_ext;
   logic signed [DIST_W-1:0] num_in [2];
   logic signed [DIST_W-1:0] num_ff [2];
   logic                     v1_valid_ff;
   coef_type                 v1_coef_ff;

   // stage 2: sign and magnitude
   logic [DIST_W-1:0] mag_in [2];
   logic [DIST_W-1:0] mag_ff [2];
   logic              neg_ff [2];
   logic              v2_valid_ff;
   coef_type          v2_coef_ff;

   // stage 3: overflow check and first remainder
   logic [MAG_W-1:0]  m_full [2];
   lane_type          lane0_in [2];
   lane_type          lane0_ff [2];
   logic              v3_valid_ff;
   coef_type          v3_coef_ff;

   always_comb begin
      h_ext     = DIST_W'($signed(in_coef.h));
      s_ext     = $signed(DIST_W'(in_root));
      num_in[0] = -h_ext - s_ext;
      num_in[1] = -h_ext + s_ext;
      for (int i = 0; i < 2; i++) begin
         mag_in[i] = num_ff[i][DIST_W-1] ? DIST_W'(-num_ff[i]) : DIST_W'(num_ff[i]);
         m_full[i] = {mag_ff[i], {FRACTION_BITS{1'b0}}};
         lane0_in[i].neg = neg_ff[i];
         // quotient of 2^32 or more saturates either way
         lane0_in[i].ovf = (MHI_W + A_W)'(m_full[i][MAG_W-1:OUT_W])
                           >= (MHI_W + A_W)'(v2_coef_ff.a);
         lane0_in[i].rem = lane0_in[i].ovf ? '0 : A_W'(m_full[i][MAG_W-1:OUT_W]);
         lane0_in[i].quo = '0;
         lane0_in[i].mlo = m_full[i][OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_valid_ff <= 1'b0;
         v2_valid_ff <= 1'b0;
         v3_valid_ff <= 1'b0;
      end else if (en) begin
         v1_valid_ff <= in_valid;
         v2_valid_ff <= v1_valid_ff;
         v3_valid_ff <= v2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff     <= num_in;
         v1_coef_ff <= in_coef;
         mag_ff     <= mag_in;
         neg_ff[0]  <= num_ff[0][DIST_W-1];
         neg_ff[1]  <= num_ff[1][DIST_W-1];
         v2_coef_ff <= v1_coef_ff;
         lane0_ff   <= lane0_in;
         v3_coef_ff <= v2_coef_ff;
      end
   end

   // divider stages
   logic     dv_valid_ff [DIV_STAGES];
   coef_type dv_coef_ff  [DIV_STAGES];
   lane_type dv_lane_ff  [DIV_STAGES][2];

   logic     dv_valid_stg [DIV_STAGES+1];
   coef_type dv_coef_stg  [DIV_STAGES+1];
   lane_type dv_lane_stg  [DIV_STAGES+1][2];

   assign dv_valid_stg[0]   = v3_valid_ff;
   assign dv_coef_stg[0]    = v3_coef_ff;
   assign dv_lane_stg[0][0] = lane0_ff[0];
   assign dv_lane_stg[0][1] = lane0_ff[1];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      lane_type       lane_in [2];
      logic [A_W:0]   cur     [2];
      logic           ge      [2];

      always_comb begin
         for (int i = 0; i < 2; i++) begin
            cur[i]         = {dv_lane_stg[k][i].rem, dv_lane_stg[k][i].mlo[OUT_W-1]};
            ge[i]          = (cur[i] >= {1'b0, dv_coef_stg[k].a});
            lane_in[i]     = dv_lane_stg[k][i];
            lane_in[i].rem = ge[i] ? A_W'(cur[i] - {1'b0, dv_coef_stg[k].a}) : A_W'(cur[i]);
            lane_in[i].quo = {dv_lane_stg[k][i].quo[OUT_W-2:0], ge[i]};
            lane_in[i].mlo = dv_lane_stg[k][i].mlo << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k] <= dv_valid_stg[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_coef_ff[k]    <= dv_coef_stg[k];
            dv_lane_ff[k][0] <= lane_in[0];
            dv_lane_ff[k][1] <= lane_in[1];
         end
      end

      assign dv_valid_stg[k+1]   = dv_valid_ff[k];
      assign dv_coef_stg[k+1]    = dv_coef_ff[k];
      assign dv_lane_stg[k+1][0] = dv_lane_ff[k][0];
      assign dv_lane_stg[k+1][1] = dv_lane_ff[k][1];
   end

   // final stage: floor toward minus infinity, saturate, miss forcing
   logic [OUT_W:0]    inc  [2];
   logic [OUT_W-1:0]  dist_sat [2];
   logic [OUT_W-1:0]  dist_in [2];
   logic [1:0]        hit_in;
   logic              fin_valid_ff;
   logic [1:0]        fin_hit_ff;
   logic [OUT_W-1:0]  fin_dist_ff [2];
   coef_type          last_coef;

   always_comb begin
      last_coef = dv_coef_stg[DIV_STAGES];
      for (int i = 0; i < 2; i++) begin
         inc[i] = (OUT_W + 1)'(dv_lane_stg[DIV_STAGES][i].quo)
                + (OUT_W + 1)'(dv_lane_stg[DIV_STAGES][i].rem != '0);
         if (!dv_lane_stg[DIV_STAGES][i].neg) begin
            if (dv_lane_stg[DIV_STAGES][i].ovf || dv_lane_stg[DIV_STAGES][i].quo[OUT_W-1]) begin
               dist_sat[i] = DIST_MAX;
            end else begin
               dist_sat[i] = dv_lane_stg[DIV_STAGES][i].quo;
            end
         end else begin
            if (dv_lane_stg[DIV_STAGES][i].ovf || inc[i][OUT_W] || inc[i][OUT_W-1]) begin
               dist_sat[i] = DIST_MIN;
            end else begin
               dist_sat[i] = OUT_W'(-inc[i][OUT_W-1:0]);
            end
         end
         dist_in[i] = last_coef.miss ? '0 : dist_sat[i];
      end
      if (last_coef.miss) begin
         hit_in = HIT_NONE;
      end else if (last_coef.q_zero) begin
         hit_in = HIT_ONE;
      end else begin
         hit_in = HIT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= dv_valid_stg[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_hit_ff  <= hit_in;
         fin_dist_ff <= dist_in;
      end
   end

   assign out_valid     = fin_valid_ff;
   assign out_hit_count = fin_hit_ff;
   assign out_near      = fin_dist_ff[0];
   assign out_far       = fin_dist_ff[1];

endmodule

`default_nettype wire

// ===== rtl/ray_sphere_intersect.sv =====
// Ray against unit sphere intersection in signed Q16.16. One transaction per
// clock is accepted and one result leaves per clock unless stalled; a ray
// passes 7 coefficient stages (products of up to 35 bits are split and
// recombined), 66 square root stages (one root bit each), 3 numerator
// stages, 32 divider stages (one quotient bit each, near and far in parallel
// lanes), one rounding and saturation stage and the output register.
// A zero direction or a negative discriminant gives hit_count 0 and zero
// distances; a tangent gives hit_count 1 with equal distances. The whole pipe
// holds while the output skid register is occupied, so req_stall is a plain
// register and never follows rsp_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "ray_sphere_intersect_defines.svh"

// ---------------------------------------------------------------------------
// ray_sphere_intersect
// top level: coefficient front end, square root, divider, output skid
// ---------------------------------------------------------------------------
module ray_sphere_intersect
   import rsi_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request transaction
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_origin_x,
   input  logic signed [COORD_W-1:0] req_origin_y,
   input  logic signed [COORD_W-1:0] req_origin_z,
   input  logic signed [COORD_W-1:0] req_direction_x,
   input  logic signed [COORD_W-1:0] req_direction_y,
   input  logic signed [COORD_W-1:0] req_direction_z,
   input  logic signed [COORD_W-1:0] req_centre_x,
   input  logic signed [COORD_W-1:0] req_centre_y,
   input  logic signed [COORD_W-1:0] req_centre_z,
   // response transaction
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_hit_count,
   output logic signed [OUT_W-1:0]   rsp_near_distance,
   output logic signed [OUT_W-1:0]   rsp_far_distance
);

   // pipe advances whenever the skid slot is free
   logic en;

   logic [2:0][COORD_W-1:0] origin, direction, centre;

   logic              coef_valid;
   coef_type          coef;
   logic [Q_W-1:0]    q;
   logic              root_valid;
   coef_type          root_coef;
   logic [ROOT_W-1:0] root;
   logic              fin_valid;
   logic [1:0]        fin_hit;
   logic [OUT_W-1:0]  fin_near, fin_far;

   // output register and skid slot
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_hit_ff, out_hit_in;
   logic [OUT_W-1:0] out_near_ff, out_near_in;
   logic [OUT_W-1:0] out_far_ff, out_far_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [1:0]       skid_hit_ff;
   logic [OUT_W-1:0] skid_near_ff, skid_far_ff;
   logic             push, out_take;

   assign en = !skid_valid_ff;

   assign origin    = {req_origin_z, req_origin_y, req_origin_x};
   assign direction = {req_direction_z, req_direction_y, req_direction_x};
   assign centre    = {req_centre_z, req_centre_y, req_centre_x};

   rsi_coef u_coef (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .in_origin    (origin),
      .in_direction (direction),
      .in_centre    (centre),
      .out_valid    (coef_valid),
      .out_coef     (coef),
      .out_q        (q)
   );

   // q below zero is a miss; its root is computed but never used
   rsi_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (coef_valid),
      .in_coef   (coef),
      .in_q      (q),
      .out_valid (root_valid),
      .out_coef  (root_coef),
      .out_root  (root)
   );

   rsi_divide u_divide (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (root_valid),
      .in_coef       (root_coef),
      .in_root       (root),
      .out_valid     (fin_valid),
      .out_hit_count (fin_hit),
      .out_near      (fin_near),
      .out_far       (fin_far)
   );

   // last pipe stage is handed over only on cycles the pipe moves
   assign push     = fin_valid && en;
   assign out_take = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_hit_in    = out_hit_ff;
      out_near_in   = out_near_ff;
      out_far_in    = out_far_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            // drain the skid slot first, pipe is held this cycle
            out_valid_in  = 1'b1;
            out_hit_in    = skid_hit_ff;
            out_near_in   = skid_near_ff;
            out_far_in    = skid_far_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_hit_in   = fin_hit;
            out_near_in  = fin_near;
            out_far_in   = fin_far;
         end
      end else if (push) begin
         // output busy, park the result
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hit_ff  <= out_hit_in;
      out_near_ff <= out_near_in;
      out_far_ff  <= out_far_in;
      if (!out_take && push) begin
         skid_hit_ff  <= fin_hit;
         skid_near_ff <= fin_near;
         skid_far_ff  <= fin_far;
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_hit_count     = out_hit_ff;
   assign rsp_near_distance = $signed(out_near_ff);
   assign rsp_far_distance  = $signed(out_far_ff);

   // skid slot only fills behind a held output
   `RSI_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // a parked result stays parked while the output is still held
   `RSI_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff)
   // a miss carries zero distances
   `RSI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && rsp_hit_count == HIT_NONE, rsp_near_distance == '0 && rsp_far_distance == '0)
   // a tangent has one distance
   `RSI_ASSERT_IMPLY(a_tangent_equal, clock, reset, rsp_valid && rsp_hit_count == HIT_ONE, rsp_near_distance == rsp_far_distance)
   // near never beyond far
   `RSI_ASSERT_IMPLY(a_near_le_far, clock, reset, rsp_valid && rsp_hit_count == HIT_TWO, rsp_near_distance <= rsp_far_distance)

endmodule

`default_nettype wire

// ===== sim/ray_sphere_intersect_tb.sv =====
// ---------------------------------------------------------------------------
// ray_sphere_intersect_tb
// streams rays at the intersect pipe under several idle and stall mixes and
// checks every hit count and distance against a wide-integer solver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect_tb
   import rsi_pkg::*;
;

   localparam int RANDOM_RAYS  = 1300;
   localparam int PIPE_LATENCY = 110;
   localparam int CYCLE_LIMIT  = 600000;

   typedef logic signed [191:0] wide_type;

   // one ray transaction: origin, direction, sphere centre
   typedef struct {
      logic signed [COORD_W-1:0] org [3];
      logic signed [COORD_W-1:0] dir [3];
      logic signed [COORD_W-1:0] ctr [3];
   } ray_type;

   typedef struct {
      logic [1:0]              hits;
      logic signed [OUT_W-1:0] near_t;
      logic signed [OUT_W-1:0] far_t;
   } crossing_type;

   // floor(n / a) for a > 0, clamped to the output range
   function automatic logic signed [OUT_W-1:0] floor_div_clamp(wide_type n, wide_type a);
      wide_type quo;
      quo = n / a;
      if (n < 0 && quo * a != n)
         quo = quo - 1;
      if (quo > wide_type'(32'sh7fffffff))
         return 32'sh7fffffff;
      if (quo < -wide_type'(64'sh80000000))
         return 32'sh80000000;
      return quo[OUT_W-1:0];
   endfunction

   // solve a*t^2 + 2*h*t + c = 0 exactly on wide integers
   function automatic crossing_type solve_ray(ray_type r);
      crossing_type res;
      wide_type dv, rv, a, h, c, q, root, cand, lo, hi;
      a = 0;
      h = 0;
      c = 0;
      for (int i = 0; i < 3; i++) begin
         dv = wide_type'(r.dir[i]);
         rv = wide_type'(r.org[i]) - wide_type'(r.ctr[i]);
         a = a + dv * dv;
         h = h + dv * rv;
         c = c + rv * rv;
      end
      c = c - (wide_type'(1) <<< (2 * FRACTION_BITS));
      res.hits = HIT_NONE;
      res.near_t = '0;
      res.far_t = '0;
      if (a == 0)
         return res;
      q = h * h - a * c;
      if (q < 0)
         return res;
      root = 0;
      for (int i = 66; i >= 0; i--) begin
         cand = root | (wide_type'(1) <<< i);
         if (cand * cand <= q)
            root = cand;
      end
      lo = (-h - root) <<< FRACTION_BITS;
      hi = (-h + root) <<< FRACTION_BITS;
      res.hits = (q == 0) ? HIT_ONE : HIT_TWO;
      res.near_t = floor_div_clamp(lo, a);
      res.far_t = floor_div_clamp(hi, a);
      return res;
   endfunction

   // expected crossings in arrival order, plus the mismatch tally
   class crossing_board_type;
      crossing_type pending[$];
      int           errors = 0;

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      function void note_ray(ray_type r);
         pending.push_back(solve_ray(r));
      endfunction

      task check_result(logic [1:0] hits, logic signed [OUT_W-1:0] near_t,
                        logic signed [OUT_W-1:0] far_t);
         crossing_type exp_res;
         if (pending.size() == 0) begin
            report("result with nothing outstanding");
            return;
         end
         exp_res = pending.pop_front();
         if (hits !== exp_res.hits)
            report($sformatf("hit_count %0d, want %0d", hits, exp_res.hits));
         if (near_t !== exp_res.near_t)
            report($sformatf("near_distance %0d, want %0d", near_t, exp_res.near_t));
         if (far_t !== exp_res.far_t)
            report($sformatf("far_distance %0d, want %0d", far_t, exp_res.far_t));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [COORD_W-1:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [COORD_W-1:0] req_direction_x, req_direction_y, req_direction_z;
   logic signed [COORD_W-1:0] req_centre_x, req_centre_y, req_centre_z;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_hit_count;
   logic signed [OUT_W-1:0] rsp_near_distance;
   logic signed [OUT_W-1:0] rsp_far_distance;

   crossing_board_type board = new();
   int  sender_idle_pct = 0;   // chance of a gap between transactions
   int  stall_pct = 0;         // chance the receiver stalls a cycle
   int  cycles = 0;

   ray_sphere_intersect u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_origin_z      (req_origin_z),
      .req_direction_x   (req_direction_x),
      .req_direction_y   (req_direction_y),
      .req_direction_z   (req_direction_z),
      .req_centre_x      (req_centre_x),
      .req_centre_y      (req_centre_y),
      .req_centre_z      (req_centre_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_near_distance (rsp_near_distance),
      .rsp_far_distance  (rsp_far_distance)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic ray_type current_ray();
      ray_type r;
      r.org = '{req_origin_x, req_origin_y, req_origin_z};
      r.dir = '{req_direction_x, req_direction_y, req_direction_z};
      r.ctr = '{req_centre_x, req_centre_y, req_centre_z};
      return r;
   endfunction

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= (int'($urandom_range(0, 99)) < stall_pct);
   end

   // both channel monitors sample pre-edge values, so no race with the drivers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_ray(current_ray());
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_hit_count, rsp_near_distance, rsp_far_distance);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("ray_sphere_intersect test failed");
         $finish;
      end
   end

   // signed value in whole units scaled to the fixed point grid, plus fraction noise
   function automatic logic signed [COORD_W-1:0] units(int lim);
      return (int'($urandom_range(0, 2 * lim)) - lim) * (1 <<< FRACTION_BITS)
             + int'($urandom_range(0, 65535));
   endfunction

   function automatic ray_type make_ray(logic signed [COORD_W-1:0] ox, oy, oz,
                                        logic signed [COORD_W-1:0] dx, dy, dz,
                                        logic signed [COORD_W-1:0] cx, cy, cz);
      ray_type r;
      r.org = '{ox, oy, oz};
      r.dir = '{dx, dy, dz};
      r.ctr = '{cx, cy, cz};
      return r;
   endfunction

   // mostly rays aimed near the sphere, some short random ones, some raw noise
   function automatic ray_type random_ray();
      ray_type r;
      int   mode;
      int   shift;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         if (mode < 2) begin
            r.org[i] = $urandom;
            r.dir[i] = $urandom;
            r.ctr[i] = $urandom;
         end else if (mode < 4) begin
            r.org[i] = units(4);
            r.dir[i] = units(2);
            r.ctr[i] = units(4);
         end else begin
            shift = $urandom_range(0, 6);
            r.ctr[i] = units(200);
            r.org[i] = r.ctr[i] + units(8);
            // point back toward the centre, scaled and jittered
            r.dir[i] = ((r.ctr[i] - r.org[i]) >>> shift) + units(0) - 32768;
         end
      end
      return r;
   endfunction

   // one transaction; valid stays high into the next unless a gap follows
   task automatic send_ray(ray_type r);
      logic stalled;
      req_valid <= 1'b1;
      req_origin_x <= r.org[0];
      req_origin_y <= r.org[1];
      req_origin_z <= r.org[2];
      req_direction_x <= r.dir[0];
      req_direction_y <= r.dir[1];
      req_direction_z <= r.dir[2];
      req_centre_x <= r.ctr[0];
      req_centre_y <= r.ctr[1];
      req_centre_z <= r.ctr[2];
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      while (int'($urandom_range(0, 99)) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   localparam logic signed [COORD_W-1:0] ONE = 1 <<< FRACTION_BITS;
   localparam logic signed [COORD_W-1:0] MAXV = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] MINV = 32'sh80000000;

   initial begin
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_origin_x, req_origin_y, req_origin_z} = '0;
      {req_direction_x, req_direction_y, req_direction_z} = '0;
      {req_centre_x, req_centre_y, req_centre_z} = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: straight hit, tangent, miss, zero direction, field extremes
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, ONE, 0, 0, 0));
      send_ray(make_ray(0, ONE, -5 * ONE, 0, 0, ONE, 0, 0, 0));
      send_ray(make_ray(0, -ONE, 5 * ONE, 0, 0, -ONE, 0, 0, 0));
      send_ray(make_ray(0, 2 * ONE, -5 * ONE, 0, 0, ONE, 0, 0, 0));
      send_ray(make_ray(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0));
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, 1, 0, 0, 0));
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, -1, 0, 0, 0));
      send_ray(make_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      send_ray(make_ray(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
      send_ray(make_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MINV));
      send_ray(make_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      send_ray(make_ray(MAXV, 0, 0, MINV, 0, 0, MINV, 0, 0));
      send_ray(make_ray(0, 0, MINV, 0, 0, 1, 0, 0, MAXV));
      send_ray(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, 0, MAXV, 0, 0, 0));

      // random phases: free running, sparse sender, heavy stall, light both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 85; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 85; end
            default: begin sender_idle_pct = 7; stall_pct = 7; end
         endcase
         for (int n = 0; n < RANDOM_RAYS / 4; n++)
            send_ray(random_ray());
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      waited = 0;
      while (board.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_LATENCY + 20) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ray_sphere_intersect test passed");
      end else begin
         if (board.pending.size() != 0)
            board.report($sformatf("%0d results never arrived", board.pending.size()));
         $display("ray_sphere_intersect test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_coef.sv
rtl/rsi_isqrt.sv
rtl/rsi_divide.sv
rtl/ray_sphere_intersect.sv
sim/ray_sphere_intersect_tb.sv
